>>> design/rdc_pkg.sv
// Shared widths, operation codes and the command bundle passed to the occurrence tally.
package rdc_pkg;

    // Fixed widths of the item fields on the ports.
    localparam int POS_W = 10;
    localparam int COL_W = 12;
    localparam int OUT_W = 11;

    // Operation codes carried by i_operation.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_operation;

    // Command from the sequencer to the occurrence tally.
    typedef struct packed {
        logic clear;   // write zero at the given colour (reset sweep)
        logic look;    // read the count of the given colour
        logic apply;   // write back the updated count of the looked-up colour
        logic add;     // apply as an addition when set, as a removal when clear
    } t_tally_cmd;

endpackage

>>> design/range_distinct_count_with_updates.sv
// Top level: colour store, window sequencer and result register of the distinct counter.
// After reset a clearing pass over max(MAX_POSITIONS, COLOUR_COUNT) addresses (4096 by default)
// zeroes both memories; busy stays high throughout and no item is accepted.
// A write outside the window is stored from idle; a write inside it keeps busy high while the old colour is removed.
// A query moves the window edges one step at a time before it strobes its result;
// each step is a colour read, a count read and a count write-back.
// Results cannot be stalled: o_strobe marks each on o_distinct_count for exactly one cycle.
module range_distinct_count_with_updates import rdc_pkg::*; #(
    parameter int MAX_POSITIONS = 1024,
    parameter int COLOUR_COUNT  = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_operation,
    input  logic [POS_W-1:0] i_position,
    input  logic [COL_W-1:0] i_colour,
    input  logic [POS_W-1:0] i_left_end,
    input  logic [POS_W-1:0] i_right_end,
    output logic             o_strobe,
    output logic [OUT_W-1:0] o_distinct_count
);

    localparam int PW        = $clog2(MAX_POSITIONS);
    localparam int PW1       = $clog2(MAX_POSITIONS + 1);
    localparam int CW        = $clog2(COLOUR_COUNT);
    localparam int NW        = $clog2(MAX_POSITIONS + 1);
    localparam int DEPTH_MAX = (MAX_POSITIONS > COLOUR_COUNT) ? MAX_POSITIONS : COLOUR_COUNT;
    localparam int CLW       = $clog2(DEPTH_MAX);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_LOOK   = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;

    // Window edge moves, in the order in which they are tried.
    localparam logic [1:0] M_GROW_L   = 2'd0;
    localparam logic [1:0] M_GROW_R   = 2'd1;
    localparam logic [1:0] M_SHRINK_L = 2'd2;
    localparam logic [1:0] M_SHRINK_R = 2'd3;

    localparam logic [31:0] MAX_U = 32'(MAX_POSITIONS);
    localparam logic [31:0] COL_U = 32'(COLOUR_COUNT);

    logic [2:0]       r_state;
    logic [CLW-1:0]   r_clr;
    logic [PW1-1:0]   r_ws;
    logic [PW1-1:0]   r_we;
    logic [PW1-1:0]   r_lo;
    logic [PW1-1:0]   r_end;
    logic [1:0]       r_move;
    logic             r_is_wr;
    logic             r_use_new;
    logic             r_add;
    logic [PW-1:0]    r_addr;
    logic [CW-1:0]    r_new_col;
    logic             r_strobe;
    logic [OUT_W-1:0] r_count;

    // The colour store: one write and one read port, read data registered.
    logic [CW-1:0]    r_cmem [MAX_POSITIONS];
    logic [CW-1:0]    r_cd;
    logic             cm_we;
    logic [PW-1:0]    cm_waddr;
    logic [CW-1:0]    cm_wdata;
    logic [PW-1:0]    cm_raddr;

    t_tally_cmd       tcmd;
    logic [CW-1:0]    t_colour;
    logic [NW-1:0]    total;

    logic             accept;
    logic [31:0]      pos_ext;
    logic [31:0]      col_ext;
    logic [31:0]      lo_ext;
    logic [31:0]      hi_ext;
    logic [PW1-1:0]   pos_w;
    logic [PW1-1:0]   lo_w;
    logic [PW1-1:0]   hi_w;
    logic [CW-1:0]    col_sat;
    logic             pos_ok;
    logic             in_window;
    logic             clr_col_ok;
    logic             clr_pos_ok;
    logic             clr_done;

    logic             any_move;
    logic [1:0]       move;
    logic [PW1-1:0]   move_addr;
    logic [NW+OUT_W-1:0] total_ext;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Input conditioning: positions beyond the array saturate (queries) or are
    // dropped (writes), and colours beyond the table saturate to the last one.
    assign pos_ext   = 32'(i_position);
    assign col_ext   = 32'(i_colour);
    assign lo_ext    = 32'(i_left_end);
    assign hi_ext    = 32'(i_right_end);
    assign pos_ok    = (pos_ext < MAX_U);
    assign pos_w     = PW1'(pos_ext);
    assign lo_w      = (lo_ext >= MAX_U) ? PW1'(MAX_U - 32'd1) : PW1'(lo_ext);
    assign hi_w      = (hi_ext >= MAX_U) ? PW1'(MAX_U - 32'd1) : PW1'(hi_ext);
    assign col_sat   = (col_ext >= COL_U) ? CW'(COL_U - 32'd1) : CW'(col_ext);
    assign in_window = (pos_w >= r_ws) && (pos_w < r_we);

    // The clearing pass walks the larger of the two depths; each memory is
    // written only while the sweep address lies inside it.
    assign clr_col_ok = (32'(r_clr) < COL_U);
    assign clr_pos_ok = (32'(r_clr) < MAX_U);
    assign clr_done   = (32'(r_clr) == 32'(DEPTH_MAX - 1));

    // Next window move: grow before shrinking, so that no count is taken
    // below zero while the window travels.
    always_comb begin
        any_move  = 1'b1;
        move      = M_GROW_L;
        move_addr = r_ws - PW1'(1);
        if (r_ws > r_lo) begin
            move      = M_GROW_L;
            move_addr = r_ws - PW1'(1);
        end else if (r_we < r_end) begin
            move      = M_GROW_R;
            move_addr = r_we;
        end else if (r_ws < r_lo) begin
            move      = M_SHRINK_L;
            move_addr = r_ws;
        end else if (r_we > r_end) begin
            move      = M_SHRINK_R;
            move_addr = r_we - PW1'(1);
        end else begin
            any_move = 1'b0;
        end
    end

    // Colour store port selection.
    always_comb begin
        cm_we    = 1'b0;
        cm_waddr = r_addr;
        cm_wdata = r_new_col;
        cm_raddr = move_addr[PW-1:0];
        case (r_state)
            S_CLEAR: begin
                cm_we    = clr_pos_ok;
                cm_waddr = r_clr[PW-1:0];
                cm_wdata = '0;
            end
            S_IDLE: begin
                cm_raddr = pos_w[PW-1:0];
                if (accept && (i_operation == OP_WRITE) && pos_ok && !in_window) begin
                    cm_we    = 1'b1;
                    cm_waddr = pos_w[PW-1:0];
                    cm_wdata = col_sat;
                end
            end
            S_UPD: begin
                cm_we = r_is_wr && !r_use_new;
            end
            default: begin
                cm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            r_cmem[cm_waddr] <= cm_wdata;
        end
        r_cd <= r_cmem[cm_raddr];
    end

    // Tally commands: the count is looked up in S_LOOK and written back in S_UPD,
    // the state that follows it, so steps never overlap.
    always_comb begin
        tcmd.clear = (r_state == S_CLEAR) && clr_col_ok;
        tcmd.look  = (r_state == S_LOOK);
        tcmd.apply = (r_state == S_UPD);
        tcmd.add   = r_add;
        if (r_state == S_CLEAR) begin
            t_colour = r_clr[CW-1:0];
        end else if (r_use_new) begin
            t_colour = r_new_col;
        end else begin
            t_colour = r_cd;
        end
    end

    rdc_tally #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .COLOUR_COUNT  (COLOUR_COUNT)
    ) u_tally (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (tcmd),
        .i_colour (t_colour),
        .o_total  (total)
    );

    assign total_ext = (NW + OUT_W)'(total);

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_ws      <= '0;
            r_we      <= '0;
            r_strobe  <= 1'b0;
            r_is_wr   <= 1'b0;
            r_use_new <= 1'b0;
            r_add     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLW'(1);
                    if (clr_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_operation == OP_WRITE) begin
                            // A write inside the window first removes the old
                            // colour, then stores and adds the new one.
                            if (pos_ok && in_window) begin
                                r_is_wr   <= 1'b1;
                                r_use_new <= 1'b0;
                                r_add     <= 1'b0;
                                r_addr    <= pos_w[PW-1:0];
                                r_new_col <= col_sat;
                                r_state   <= S_LOOK;
                            end
                        end else if (lo_w > hi_w) begin
                            // An empty range answers zero and leaves the window.
                            r_strobe <= 1'b1;
                            r_count  <= '0;
                        end else begin
                            r_is_wr   <= 1'b0;
                            r_use_new <= 1'b0;
                            r_lo      <= lo_w;
                            r_end     <= hi_w + PW1'(1);
                            r_state   <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (any_move) begin
                        r_move  <= move;
                        r_add   <= (move == M_GROW_L) || (move == M_GROW_R);
                        r_state <= S_LOOK;
                    end else begin
                        r_strobe <= 1'b1;
                        r_count  <= total_ext[OUT_W-1:0];
                        r_state  <= S_IDLE;
                    end
                end
                S_LOOK: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_is_wr) begin
                        if (!r_use_new) begin
                            r_use_new <= 1'b1;
                            r_add     <= 1'b1;
                            r_state   <= S_LOOK;
                        end else begin
                            r_use_new <= 1'b0;
                            r_is_wr   <= 1'b0;
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        case (r_move)
                            M_GROW_L:   r_ws <= r_ws - PW1'(1);
                            M_GROW_R:   r_we <= r_we + PW1'(1);
                            M_SHRINK_L: r_ws <= r_ws + PW1'(1);
                            M_SHRINK_R: r_we <= r_we - PW1'(1);
                            default:    r_ws <= r_ws;
                        endcase
                        r_state <= S_DECIDE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe         = r_strobe;
    assign o_distinct_count = r_count;

endmodule

>>> design/rdc_tally.sv
// Occurrence-count memory with read-modify-write and the distinct-colour total.
module rdc_tally import rdc_pkg::*; #(
    parameter int MAX_POSITIONS = 1024,
    parameter int COLOUR_COUNT  = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_tally_cmd                             i_cmd,
    input  logic [$clog2(COLOUR_COUNT)-1:0]        i_colour,
    output logic [$clog2(MAX_POSITIONS+1)-1:0]     o_total
);

    localparam int CW = $clog2(COLOUR_COUNT);
    localparam int NW = $clog2(MAX_POSITIONS + 1);

    logic [NW-1:0] r_mem [COLOUR_COUNT];
    logic [NW-1:0] r_rd;
    logic [CW-1:0] r_col;
    logic [NW-1:0] r_total;
    logic [NW-1:0] n_cnt;
    logic [NW-1:0] n_total;

    // A removal from a count that is already zero leaves it at zero.
    always_comb begin
        n_cnt   = r_rd;
        n_total = r_total;
        if (i_cmd.add) begin
            n_cnt = r_rd + NW'(1);
            if (r_rd == '0) begin
                n_total = r_total + NW'(1);
            end
        end else if (r_rd != '0) begin
            n_cnt = r_rd - NW'(1);
            if (r_rd == NW'(1)) begin
                n_total = r_total - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[i_colour] <= '0;
        end else if (i_cmd.apply) begin
            r_mem[r_col] <= n_cnt;
        end
        r_rd <= r_mem[i_colour];
        if (i_cmd.look) begin
            r_col <= i_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.apply) begin
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule
